// ===== rtl/kctmm_pkg.sv =====
package kctmm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_W       = 32;
  localparam int COUNT_W     = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ADDR_W:0]    ptr_t;

  localparam logic REQ_INC = 1'b0;
  localparam logic REQ_DEC = 1'b1;

  localparam count_t COUNT_MAX = '1;
  localparam ptr_t   DEPTH_P   = ptr_t'(TABLE_DEPTH);

endpackage

// ===== rtl/kctmm_if.sv =====
interface kctmm_in_if import kctmm_pkg::*; ();
  logic valid;
  logic ready;
  logic req_type;
  key_t key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface kctmm_out_if import kctmm_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   table_empty;
  key_t   max_key;
  key_t   min_key;
  count_t key_count;
  logic   full_error;

  modport source (output valid, output table_empty, output max_key, output min_key,
                  output key_count, output full_error, input ready);
  modport sink (input valid, input table_empty, input max_key, input min_key,
                input key_count, input full_error, output ready);
endinterface

// ===== rtl/key_count_table_max_min.sv =====
// Key count table: holds up to TABLE_DEPTH distinct keys with nonzero counts.
// Each input word increments (req_type 0) or decrements (req_type 1) one key;
// a new key goes to the lowest free slot, a count reaching zero frees its slot,
// and counts saturate. One result word follows every input word: the new count
// of the key, the keys with greatest and least count (lowest slot on ties), an
// empty flag and a full flag for a new key that found no free slot. Each word
// takes one pass over the slot memory for lookup, an update step and one pass
// for the max/min search, all through the single read port of the key and
// count memories. The input is not ready while a word is in process; a finished
// result waits in the output register while the next word is accepted. Counts
// read as zero after reset.
module key_count_table_max_min import kctmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kctmm_in_if.sink    in_i,
  kctmm_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_SRCH,
    ST_FIN
  } state_e;

  state_e state_q;

  key_t   key_mem [TABLE_DEPTH];
  count_t cnt_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_q;

  logic   op_q;
  key_t   key_q;
  ptr_t   addr_q;
  logic   rv_q;
  addr_t  slot_q;
  key_t   key_rd_q;
  count_t cnt_raw_q;
  logic   vld_rd_q;
  count_t cnt_cur;

  logic   hit_q;
  addr_t  hit_slot_q;
  count_t hit_cnt_q;
  logic   free_q;
  addr_t  free_slot_q;
  count_t new_cnt_q;
  logic   full_q;

  logic   any_q;
  count_t max_cnt_q;
  count_t min_cnt_q;
  key_t   max_key_q;
  key_t   min_key_q;

  logic   out_valid_q;
  logic   out_empty_q;
  key_t   out_max_q;
  key_t   out_min_q;
  count_t out_cnt_q;
  logic   out_full_q;

  logic   wr_en;
  logic   wr_key_en;
  addr_t  wr_slot;
  count_t wr_cnt;
  logic   scan_done;

  assign cnt_cur   = vld_rd_q ? cnt_raw_q : '0;
  assign scan_done = (addr_q == DEPTH_P) && !rv_q;

  always_comb begin
    wr_en     = 1'b0;
    wr_key_en = 1'b0;
    wr_slot   = hit_slot_q;
    wr_cnt    = hit_cnt_q;
    if (state_q == ST_UPD) begin
      if (op_q == REQ_INC) begin
        if (hit_q) begin
          wr_en  = 1'b1;
          wr_cnt = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + count_t'(1);
        end else if (free_q) begin
          wr_en     = 1'b1;
          wr_key_en = 1'b1;
          wr_slot   = free_slot_q;
          wr_cnt    = count_t'(1);
        end
      end else if (hit_q) begin
        wr_en  = 1'b1;
        wr_cnt = hit_cnt_q - count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_slot] <= key_q;
    end
    if (wr_en) begin
      cnt_mem[wr_slot] <= wr_cnt;
    end
    key_rd_q  <= key_mem[addr_q[ADDR_W-1:0]];
    cnt_raw_q <= cnt_mem[addr_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      op_q        <= REQ_INC;
      key_q       <= '0;
      addr_q      <= '0;
      rv_q        <= 1'b0;
      slot_q      <= '0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      hit_cnt_q   <= '0;
      free_q      <= 1'b0;
      free_slot_q <= '0;
      new_cnt_q   <= '0;
      full_q      <= 1'b0;
      any_q       <= 1'b0;
      max_cnt_q   <= '0;
      min_cnt_q   <= '0;
      max_key_q   <= '0;
      min_key_q   <= '0;
      out_valid_q <= 1'b0;
      out_empty_q <= 1'b0;
      out_max_q   <= '0;
      out_min_q   <= '0;
      out_cnt_q   <= '0;
      out_full_q  <= 1'b0;
    end else begin
      vld_rd_q <= vld_q[addr_q[ADDR_W-1:0]];
      if (out_valid_q && out_o.ready && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_LOOK || state_q == ST_SRCH) begin
        if (addr_q != DEPTH_P) begin
          addr_q <= addr_q + ptr_t'(1);
        end
        slot_q <= addr_q[ADDR_W-1:0];
        rv_q   <= (addr_q != DEPTH_P);
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.req_type;
            key_q   <= in_i.key;
            addr_q  <= '0;
            rv_q    <= 1'b0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (rv_q) begin
            if (cnt_cur != '0) begin
              if (!hit_q && key_rd_q == key_q) begin
                hit_q      <= 1'b1;
                hit_slot_q <= slot_q;
                hit_cnt_q  <= cnt_cur;
              end
            end else if (!free_q) begin
              free_q      <= 1'b1;
              free_slot_q <= slot_q;
            end
          end
          if (scan_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (wr_en) begin
            vld_q[wr_slot] <= 1'b1;
          end
          new_cnt_q <= wr_en ? wr_cnt : '0;
          full_q    <= (op_q == REQ_INC) && !hit_q && !free_q;
          addr_q    <= '0;
          rv_q      <= 1'b0;
          any_q     <= 1'b0;
          state_q   <= ST_SRCH;
        end
        ST_SRCH: begin
          if (rv_q && cnt_cur != '0) begin
            any_q <= 1'b1;
            if (!any_q || cnt_cur > max_cnt_q) begin
              max_cnt_q <= cnt_cur;
              max_key_q <= key_rd_q;
            end
            if (!any_q || cnt_cur < min_cnt_q) begin
              min_cnt_q <= cnt_cur;
              min_key_q <= key_rd_q;
            end
          end
          if (scan_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_empty_q <= !any_q;
            out_max_q   <= any_q ? max_key_q : '0;
            out_min_q   <= any_q ? min_key_q : '0;
            out_cnt_q   <= new_cnt_q;
            out_full_q  <= full_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.table_empty = out_empty_q;
  assign out_o.max_key     = out_max_q;
  assign out_o.min_key     = out_min_q;
  assign out_o.key_count   = out_cnt_q;
  assign out_o.full_error  = out_full_q;

`ifndef SYNTHESIS
  a_full_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.full_error |-> out_o.key_count == '0)
    else $error("full_error with nonzero key_count");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.table_empty |-> out_o.max_key == '0 && out_o.min_key == '0
      && out_o.key_count == '0)
    else $error("empty table result carries a key or count");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_LOOK && addr_q == '0 && !hit_q && !free_q)
    else $error("lookup pass did not start cleanly");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside finish state");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import kctmm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORD_TARGET = 815;
  localparam int QUIET_FROM  = 30_000;
  localparam int QUIET_TO    = 60_000;

  typedef struct packed {
    logic   table_empty;
    key_t   max_key;
    key_t   min_key;
    count_t key_count;
    logic   full_error;
  } report_t;

  typedef struct {
    logic    req;
    key_t    key;
    bit      typed;
    report_t exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  kctmm_in_if  in_if ();
  kctmm_out_if out_if ();

  key_count_table_max_min dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shadow of the slot memories
  key_t   key_mem [TABLE_DEPTH];
  count_t cnt_mem [TABLE_DEPTH] = '{default: '0};

  report_t report_q [$];
  report_t got_word;
  report_t want_word;
  int      errors      = 0;
  int      cycle_cnt   = 0;
  int      applied_cnt = 0;

  // directed rows, the first ten with typed results: empty table, extremes, ties, removal, decrement of an absent key
  dir_row_t dir_rows [19] = '{
    '{REQ_DEC, 32'h0000_0005, 1'b1, '{1'b1, 32'h0,         32'h0,         16'd0, 1'b0}},
    '{REQ_INC, 32'h0000_0000, 1'b1, '{1'b0, 32'h0,         32'h0,         16'd1, 1'b0}},
    '{REQ_INC, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0,         32'h0,         16'd1, 1'b0}},
    '{REQ_INC, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'hFFFF_FFFF, 32'h0,         16'd2, 1'b0}},
    '{REQ_DEC, 32'h0000_0000, 1'b1, '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b0}},
    '{REQ_INC, 32'h1234_5678, 1'b1, '{1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 16'd1, 1'b0}},
    '{REQ_DEC, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h1234_5678, 32'h1234_5678, 16'd1, 1'b0}},
    '{REQ_DEC, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h1234_5678, 32'h1234_5678, 16'd0, 1'b0}},
    '{REQ_DEC, 32'h1234_5678, 1'b1, '{1'b1, 32'h0,         32'h0,         16'd0, 1'b0}},
    '{REQ_DEC, 32'h1234_5678, 1'b1, '{1'b1, 32'h0,         32'h0,         16'd0, 1'b0}},
    '{REQ_INC, 32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_INC, 32'h5555_5555, 1'b0, '0},
    '{REQ_INC, 32'h5555_5555, 1'b0, '0},
    '{REQ_INC, 32'h8000_0000, 1'b0, '0},
    '{REQ_INC, 32'h0000_0001, 1'b0, '0},
    '{REQ_DEC, 32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_INC, 32'h0000_0001, 1'b0, '0},
    '{REQ_INC, 32'h0000_0001, 1'b0, '0},
    '{REQ_DEC, 32'h5555_5555, 1'b0, '0}
  };

  assign got_word = {out_if.table_empty, out_if.max_key, out_if.min_key,
                     out_if.key_count, out_if.full_error};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit in_quiet();
    return cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO;
  endfunction

  function automatic int slot_of(key_t k);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cnt_mem[i] != '0 && key_mem[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int held_total();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cnt_mem[i] != '0) n++;
    end
    return n;
  endfunction

  function automatic bit pick_held(output key_t k);
    int start;
    start = $urandom_range(TABLE_DEPTH - 1);
    k = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cnt_mem[(start + i) % TABLE_DEPTH] != '0) begin
        k = key_mem[(start + i) % TABLE_DEPTH];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic key_t rand_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return key_t'(1) << $urandom_range(KEY_W - 1);
      3: return ~(key_t'(1) << $urandom_range(KEY_W - 1));
      default: return key_t'($urandom);
    endcase
  endfunction

  // applies one word to the shadow table and returns the report it yields
  function automatic report_t update_counts(logic req, key_t k, output bit applied);
    int      hit;
    int      free_slot;
    int      hi_slot;
    int      lo_slot;
    report_t r;
    hit = -1;
    free_slot = -1;
    hi_slot = -1;
    lo_slot = -1;
    r = '0;
    applied = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cnt_mem[i] != '0) begin
        if (hit < 0 && key_mem[i] == k) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (req == REQ_INC) begin
      if (hit >= 0) begin
        if (cnt_mem[hit] != COUNT_MAX) cnt_mem[hit] = cnt_mem[hit] + 1'b1;
        r.key_count = cnt_mem[hit];
        applied = 1'b1;
      end else if (free_slot >= 0) begin
        key_mem[free_slot] = k;
        cnt_mem[free_slot] = count_t'(1);
        r.key_count = count_t'(1);
        applied = 1'b1;
      end else begin
        r.full_error = 1'b1;
      end
    end else if (hit >= 0) begin
      cnt_mem[hit] = cnt_mem[hit] - 1'b1;
      r.key_count = cnt_mem[hit];
      applied = 1'b1;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cnt_mem[i] != '0) begin
        if (hi_slot < 0 || cnt_mem[i] > cnt_mem[hi_slot]) hi_slot = i;
        if (lo_slot < 0 || cnt_mem[i] < cnt_mem[lo_slot]) lo_slot = i;
      end
    end
    r.table_empty = (hi_slot < 0);
    if (hi_slot >= 0) begin
      r.max_key = key_mem[hi_slot];
      r.min_key = key_mem[lo_slot];
    end
    return r;
  endfunction

  task automatic send_word(logic req, key_t k, bit typed, report_t typed_exp);
    report_t pred;
    bit      applied;
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.key      <= k;
    do @(posedge clk_i); while (!in_if.ready);
    pred = update_counts(req, k, applied);
    report_q.push_back(typed ? typed_exp : pred);
    if (applied) applied_cnt++;
    if (!in_quiet() && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2 * TABLE_DEPTH + 20)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (report_q.size() != 0);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= in_quiet() || ($urandom_range(99) >= 6);
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %h",
                 $time, got_word);
        errors++;
      end else begin
        want_word = report_q.pop_front();
        check_field("table_empty", 64'(want_word.table_empty),
                    64'(got_word.table_empty));
        check_field("max_key", 64'(want_word.max_key), 64'(got_word.max_key));
        check_field("min_key", 64'(want_word.min_key), 64'(got_word.min_key));
        check_field("key_count", 64'(want_word.key_count), 64'(got_word.key_count));
        check_field("full_error", 64'(want_word.full_error),
                    64'(got_word.full_error));
      end
    end
  end

  initial begin
    key_t k;
    key_t pool [16];
    int   npool;
    rst_ni          = 1'b0;
    in_if.valid    <= 1'b0;
    in_if.req_type <= REQ_INC;
    in_if.key      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].req, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].exp);
    end
    wait_idle();

    while (applied_cnt < WORD_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // churn on a small key pool
          npool = $urandom_range(2, 12);
          for (int i = 0; i < npool; i++) pool[i] = rand_key();
          repeat ($urandom_range(20, 60)) begin
            send_word(($urandom_range(99) < 60) ? REQ_INC : REQ_DEC,
                      pool[$urandom_range(npool - 1)], 1'b0, '0);
          end
        end
        4: begin
          // fill every slot, then push new keys into the full table
          while (held_total() < TABLE_DEPTH) begin
            do k = rand_key(); while (slot_of(k) >= 0);
            send_word(REQ_INC, k, 1'b0, '0);
          end
          repeat ($urandom_range(1, 4)) begin
            do k = key_t'($urandom); while (slot_of(k) >= 0);
            send_word(REQ_INC, k, 1'b0, '0);
          end
          repeat ($urandom_range(10, 30)) begin
            case ($urandom_range(2))
              0: begin
                do k = key_t'($urandom); while (slot_of(k) >= 0);
                send_word(REQ_INC, k, 1'b0, '0);
              end
              1: if (pick_held(k)) send_word(REQ_INC, k, 1'b0, '0);
              default: if (pick_held(k)) send_word(REQ_DEC, k, 1'b0, '0);
            endcase
          end
        end
        5, 6, 7: begin
          // drain held keys, possibly down to empty, then decrement a random key
          repeat ($urandom_range(40, 150)) begin
            if (pick_held(k)) send_word(REQ_DEC, k, 1'b0, '0);
          end
          send_word(REQ_DEC, rand_key(), 1'b0, '0);
        end
        8: begin
          repeat ($urandom_range(5, 15)) begin
            send_word(logic'($urandom_range(1)), key_t'($urandom), 1'b0, '0);
          end
        end
        default: wait_idle();
      endcase
    end

    wait_idle();
    repeat (2 * TABLE_DEPTH + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kctmm_pkg.sv
rtl/kctmm_if.sv
rtl/key_count_table_max_min.sv
bench/tb_top.sv
